@@ hw/rtl/preemptive_priority_scheduler_assert.svh @@
// assertion macros for the preemptive priority scheduler
// expects clk and rst in the scope of each use; no other dependencies
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPS_ASSERT_SAME(lbl, ante, cons, msg)
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/pps_pkg.sv @@
// shared types and constants for the preemptive priority scheduler
// no dependencies
package pps_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  prio_level;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        idle;
    logic [7:0]  running_id;
    logic        segment_start;
    logic        finished;
    logic [15:0] completion_time;
    logic [15:0] turnaround_time;
    logic [15:0] waiting_time;
    logic        all_done;
  } out_item_t;

  // slot contents as they travel down the cell chain
  typedef struct packed {
    logic        found;
    logic [7:0]  ident;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  level;
  } cand_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic dec;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_COMMIT
  } state_t;

endpackage

@@ hw/rtl/pps_cell.sv @@
// one process slot of the scheduler chain plus its stage of the best-candidate search
// depends on pps_pkg
module pps_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]      sel,
  input  pps_pkg::cand_t     ld,
  input  logic [15:0]        now,
  input  pps_pkg::cand_t     cand_in,
  input  logic [IW-1:0]      idx_in,
  output pps_pkg::cand_t     cand_out,
  output logic [IW-1:0]      idx_out
);
  import pps_pkg::*;

  logic        valid;
  logic [7:0]  ident;
  logic [15:0] arrival;
  logic [15:0] burst;
  logic [15:0] remaining;
  logic [7:0]  level;

  logic hit;
  logic eligible;
  logic better;
  cand_t own;

  assign hit      = (sel == IW'(INDEX));
  assign eligible = valid && (remaining != 16'd0) && (arrival <= now);
  assign better   = !cand_in.found || (level < cand_in.level) ||
                    ((level == cand_in.level) && (arrival < cand_in.arrival));

  always_comb begin
    own.found     = 1'b1;
    own.ident     = ident;
    own.arrival   = arrival;
    own.burst     = burst;
    own.remaining = remaining;
    own.level     = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.load && hit) begin
      valid <= ld.found;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && hit) begin
      ident     <= ld.ident;
      arrival   <= ld.arrival;
      burst     <= ld.burst;
      remaining <= ld.remaining;
      level     <= ld.level;
    end else if (ctrl.dec && hit) begin
      remaining <= remaining - 16'd1;
    end
  end

  // ties keep the upstream candidate, so lower slots win
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
      idx_out  <= '0;
    end else if (eligible && better) begin
      cand_out <= own;
      idx_out  <= IW'(INDEX);
    end else begin
      cand_out <= cand_in;
      idx_out  <= idx_in;
    end
  end

endmodule

@@ hw/rtl/preemptive_priority_scheduler.sv @@
// top level of the preemptive priority scheduler: control, timing math, output register
// depends on pps_pkg, pps_cell and preemptive_priority_scheduler_assert.svh
//
// Preemptive priority scheduler over SLOTS process slots held in a chain of cells.
// A load or clear transaction gives no result. A tick transaction passes through the
// scan, calc and commit states: the best candidate ripples through the cell chain one
// slot per cycle, then the calc step captures the winner and forms the turnaround, and
// the commit step forms the waiting time and writes the result. The next command is
// taken in the cycle after the tick has been written to the result register, so a tick
// is never overlapped by the next; a result that is not taken holds the following tick
// in its final step. Smaller priority numbers win, ties go to the earlier arrival and
// then to the lower slot (earlier load). Time and completion saturate at 65535; waiting
// time floors at zero. Reset and clear take effect at once, with no sweep over the
// slots.
`include "preemptive_priority_scheduler_assert.svh"

module preemptive_priority_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  pps_pkg::in_item_t   cmd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output pps_pkg::out_item_t  res_data
);
  import pps_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;

  logic [IW-1:0] scan_cnt;
  logic [15:0]   current_tick;
  logic [15:0]   comp;
  logic [CW-1:0] loaded_count;
  logic [CW-1:0] done_count;
  logic          last_none;
  logic          last_idle;
  logic [IW-1:0] last_idx;

  cand_t         win;
  logic [IW-1:0] win_idx;
  logic [15:0]   turn;
  logic          fin;

  logic          cmd_fire;
  logic          res_load;
  cell_ctrl_t    ctrl;
  logic [IW-1:0] sel;
  cand_t         ld;
  logic [15:0]   burst_fixed;

  logic [15:0]   wait_val;
  logic [CW-1:0] done_after;
  out_item_t     res_next;

  // chain wires: entry i feeds cell i, entry SLOTS is the winner
  cand_t         cand_w [SLOTS+1];
  logic [IW-1:0] idx_w  [SLOTS+1];

  assign cand_w[0] = '0;
  assign idx_w[0]  = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    pps_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sel      (sel),
      .ld       (ld),
      .now      (current_tick),
      .cand_in  (cand_w[i]),
      .idx_in   (idx_w[i]),
      .cand_out (cand_w[i+1]),
      .idx_out  (idx_w[i+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_fire && (cmd_data.command == CMD_TICK)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        // the scan ends once the winner of all SLOTS chain cells reaches the last cell
        if (scan_cnt == IW'(SLOTS - 1)) state_next = ST_CALC;
      end
      ST_CALC: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (res_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready  = (state == ST_IDLE);
    cmd_fire   = cmd_valid && cmd_ready;
    res_load   = (state == ST_COMMIT) && (!res_valid || res_ready);
    ctrl.load  = cmd_fire && (cmd_data.command == CMD_LOAD) &&
                 (loaded_count < CW'(SLOTS));
    ctrl.clear = cmd_fire && (cmd_data.command == CMD_CLEAR);
    ctrl.dec   = res_load && win.found;
    // loads happen only in idle, decrements only at commit
    sel        = ctrl.dec ? win_idx : loaded_count[IW-1:0];
  end

  // load data, zero burst becomes one
  always_comb begin
    burst_fixed  = (cmd_data.burst_time == 16'd0) ? 16'd1 : cmd_data.burst_time;
    ld.found     = 1'b1;
    ld.ident     = cmd_data.proc_id;
    ld.arrival   = cmd_data.arrival_time;
    ld.burst     = burst_fixed;
    ld.remaining = burst_fixed;
    ld.level     = cmd_data.prio_level;
  end

  // result fields
  always_comb begin
    wait_val   = (turn > win.burst) ? (turn - win.burst) : 16'd0;
    done_after = done_count + CW'(fin);

    res_next.tick_time       = current_tick;
    res_next.idle            = !win.found;
    res_next.running_id      = win.found ? win.ident : 8'd0;
    if (win.found) begin
      res_next.segment_start = last_none || last_idle || (last_idx != win_idx);
    end else begin
      res_next.segment_start = !last_idle;
    end
    res_next.finished        = fin;
    res_next.completion_time = fin ? comp : 16'd0;
    res_next.turnaround_time = fin ? turn : 16'd0;
    res_next.waiting_time    = fin ? wait_val : 16'd0;
    res_next.all_done        = (done_after == loaded_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + IW'(1);
    end else begin
      scan_cnt <= '0;
    end
  end

  // completion time is fixed by the tick, so it is formed at acceptance
  always_ff @(posedge clk) begin
    if (cmd_fire && (cmd_data.command == CMD_TICK)) begin
      comp <= (current_tick == TIME_MAX) ? TIME_MAX : current_tick + 16'd1;
    end
  end

  // capture the winner at the end of the chain
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      win     <= cand_w[SLOTS];
      win_idx <= idx_w[SLOTS];
      turn    <= comp - cand_w[SLOTS].arrival;
      fin     <= cand_w[SLOTS].found && (cand_w[SLOTS].remaining == 16'd1);
    end
  end

  // scheduler bookkeeping
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      current_tick <= '0;
      loaded_count <= '0;
      done_count   <= '0;
      last_none    <= 1'b1;
      last_idle    <= 1'b0;
      last_idx     <= '0;
    end else begin
      if (ctrl.load) loaded_count <= loaded_count + CW'(1);
      if (res_load) begin
        if (current_tick != TIME_MAX) current_tick <= current_tick + 16'd1;
        done_count <= done_after;
        last_none  <= 1'b0;
        last_idle  <= !win.found;
        last_idx   <= win_idx;
      end
    end
  end

  // result register, a held result keeps the next tick in commit
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res_data <= res_next;
  end

  `PPS_ASSERT_SAME(a_done_bound, 1'b1, done_count <= loaded_count, "done count above loaded count")
  `PPS_ASSERT_SAME(a_result_from_commit, $rose(res_valid), $past(state) == ST_COMMIT, "result without commit")
  `PPS_ASSERT_NEXT(a_tick_scans, cmd_fire && (cmd_data.command == CMD_TICK), state == ST_SCAN, "tick did not start scan")
  `PPS_ASSERT_NEXT(a_time_hold, !res_load && !ctrl.clear, $stable(current_tick), "time moved outside a tick")

endmodule
